// ----- rtl/core/bsst_pkg.sv -----
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types for the bounded set span tracker: the link between cells.
// ----------------------------------------------------------------------------
package bsst_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned CAP_W = 7;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic [KEY_W-1:0] val;  // stored key, offset binary
        logic             gt;   // occupied and stored key above the new key
        logic             occ;  // entry below the held count
    } link_t;

endpackage

// ----- rtl/core/bsst_cell.sv -----
// ----------------------------------------------------------------------------
// bsst_cell
// One slot of the sorted chain: holds a key, shifts right on insert, and
// registers its gap to the new key when it is the new key's neighbor.
// ----------------------------------------------------------------------------
module bsst_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 7
) (
    input  logic                         clk,
    input  logic                         load,     // beat accepted
    input  logic                         ins,      // beat accepted and stored
    input  logic [bsst_pkg::KEY_W-1:0]   key,
    input  logic [CW-1:0]                count,
    input  bsst_pkg::link_t              left,
    input  bsst_pkg::link_t              right,
    output bsst_pkg::link_t              self,
    output logic [bsst_pkg::KEY_W-1:0]   lo_gap,   // key minus predecessor
    output logic [bsst_pkg::KEY_W-1:0]   hi_gap    // successor minus key
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [bsst_pkg::KEY_W-1:0] val_reg;
    logic [bsst_pkg::KEY_W-1:0] val_next;
    logic [bsst_pkg::KEY_W-1:0] lo_gap_reg;
    logic [bsst_pkg::KEY_W-1:0] lo_gap_next;
    logic [bsst_pkg::KEY_W-1:0] hi_gap_reg;
    logic [bsst_pkg::KEY_W-1:0] hi_gap_next;
    logic                       occ;
    logic                       gt;
    logic                       at_end;
    logic                       is_pred;
    logic                       is_succ;

    always_comb
    begin
        occ     = (MY_IDX < count);
        gt      = occ && (val_reg > key);
        at_end  = (MY_IDX == count);
        // last held entry not above key, with next one above or empty
        is_pred = occ && !gt && (!right.occ || right.gt);
        // first entry above key
        is_succ = gt && !left.gt;

        val_next = val_reg;
        if (ins && (gt || at_end))
        begin
            val_next = left.gt ? left.val : key;
        end

        lo_gap_next = is_pred ? (key - val_reg) : '1;
        hi_gap_next = is_succ ? (val_reg - key) : '1;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (load)
        begin
            lo_gap_reg <= lo_gap_next;
            hi_gap_reg <= hi_gap_next;
        end
    end

    assign self.val = val_reg;
    assign self.gt  = gt;
    assign self.occ = occ;
    assign lo_gap   = lo_gap_reg;
    assign hi_gap   = hi_gap_reg;

endmodule

// ----- rtl/core/bounded_set_span_tracker.sv -----
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Sorted set of signed values with count, smallest neighbor gap and range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value): one signed 32-bit value a beat.
//   Output channel (out_valid/out_ready): one result beat per input beat,
//   in order: status, count, spans_valid, shortest_span, longest_span.
//   Config channel (cfg_valid/cfg_ready, cfg_data): capacity, always ready;
//   write it only while no beat is in flight.
//   Throughput: one beat per cycle while out_ready keeps up; the chain of
//   cells inserts and registers the neighbor gaps, then the gap stage
//   reduces the two neighbor gaps and updates the shortest span.
//   Reset: the set is empty, capacity is 64, no result is pending. The
//   store itself is not cleared; only entries below the count are used.
//   Stall: a result waits in the output register; one more beat may sit in
//   the gap stage, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsst_pkg::CAP_W-1:0]          cfg_data,
    // input beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [31:0]                  value,
    // result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic [$clog2(STORE_DEPTH+1)-1:0]    count,
    output logic                                spans_valid,
    output logic [31:0]                         shortest_span,
    output logic [31:0]                         longest_span
);

    localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > bsst_pkg::CAP_W) ? CW : bsst_pkg::CAP_W;
    localparam int unsigned KW   = bsst_pkg::KEY_W;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(STORE_DEPTH);
    localparam logic [bsst_pkg::CAP_W-1:0] CAP_RESET = bsst_pkg::CAP_W'(64);
    localparam logic [KW-1:0] SIGN_BIAS = {1'b1, {(KW-1){1'b0}}};

    // control and state
    logic [bsst_pkg::CAP_W-1:0] capacity_reg;
    logic [CW-1:0]              held_count_reg;
    logic [CW-1:0]              held_count_next;
    logic [KW-1:0]              smallest_reg;
    logic [KW-1:0]              smallest_next;
    logic [KW-1:0]              largest_reg;
    logic [KW-1:0]              largest_next;
    logic [KW-1:0]              min_gap_reg;
    logic [KW-1:0]              min_gap_next;

    // gap stage
    logic                       s1_valid_reg;
    logic                       s1_status_reg;
    logic [CW-1:0]              s1_count_reg;
    logic [KW-1:0]              s1_span_reg;

    // output register
    logic                       out_valid_reg;
    logic                       out_status_reg;
    logic [CW-1:0]              out_count_reg;
    logic                       out_sv_reg;
    logic [KW-1:0]              out_short_reg;
    logic [KW-1:0]              out_long_reg;

    logic [KW-1:0]              key;
    logic [CMPW-1:0]            cap_wide;
    logic [CW-1:0]              cap_eff;
    logic                       full;
    logic                       accept;
    logic                       ins;
    logic                       s1_go;
    logic [KW-1:0]              lo_and;
    logic [KW-1:0]              hi_and;
    logic [KW-1:0]              gap_pick;

    bsst_pkg::link_t            links [STORE_DEPTH];
    logic [KW-1:0]              lo_gaps [STORE_DEPTH];
    logic [KW-1:0]              hi_gaps [STORE_DEPTH];

    localparam bsst_pkg::link_t EMPTY_LINK = '{val: '0, gt: 1'b0, occ: 1'b0};

    assign key = KW'(value) ^ SIGN_BIAS;   // offset binary: unsigned order

    // effective capacity saturates at the store depth
    always_comb
    begin
        cap_wide = CMPW'(capacity_reg);
        if (cap_wide > DEPTH_C)
        begin
            cap_wide = DEPTH_C;
        end
        cap_eff = cap_wide[CW-1:0];
    end

    assign full      = (held_count_reg >= cap_eff);
    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign accept    = in_valid && in_ready;
    assign ins       = accept && !full;
    assign cfg_ready = 1'b1;

    // chain of sorted cells
    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++)
        begin : g_cell
            bsst_pkg::link_t left_l;
            bsst_pkg::link_t right_l;
            if (gi == 0)
            begin : g_first
                assign left_l = EMPTY_LINK;
            end
            else
            begin : g_mid_l
                assign left_l = links[gi-1];
            end
            if (gi == STORE_DEPTH - 1)
            begin : g_last
                assign right_l = EMPTY_LINK;
            end
            else
            begin : g_mid_r
                assign right_l = links[gi+1];
            end

            bsst_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk    (clk),
                .load   (accept),
                .ins    (ins),
                .key    (key),
                .count  (held_count_reg),
                .left   (left_l),
                .right  (right_l),
                .self   (links[gi]),
                .lo_gap (lo_gaps[gi]),
                .hi_gap (hi_gaps[gi])
            );
        end
    endgenerate

    // insert side: count and extremes
    always_comb
    begin
        held_count_next = held_count_reg;
        smallest_next   = smallest_reg;
        largest_next    = largest_reg;
        if (ins)
        begin
            held_count_next = held_count_reg + CW'(1);
            if (held_count_reg == '0)
            begin
                smallest_next = key;
                largest_next  = key;
            end
            else
            begin
                if (key < smallest_reg)
                begin
                    smallest_next = key;
                end
                if (key > largest_reg)
                begin
                    largest_next = key;
                end
            end
        end
    end

    // at most one cell per vector holds a real gap; the rest are all ones
    always_comb
    begin
        lo_and = '1;
        hi_and = '1;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            lo_and = lo_and & lo_gaps[i];
            hi_and = hi_and & hi_gaps[i];
        end
        gap_pick     = (lo_and < hi_and) ? lo_and : hi_and;
        min_gap_next = min_gap_reg;
        if (!s1_status_reg && (gap_pick < min_gap_reg))
        begin
            min_gap_next = gap_pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            held_count_reg <= '0;
            smallest_reg   <= '0;
            largest_reg    <= '0;
            min_gap_reg    <= '1;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            held_count_reg <= held_count_next;
            smallest_reg   <= smallest_next;
            largest_reg    <= largest_next;

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                min_gap_reg   <= min_gap_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= full;
            s1_count_reg  <= held_count_next;
            s1_span_reg   <= largest_next - smallest_next;
        end
        if (s1_go)
        begin
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
            if (s1_count_reg >= CW'(2))
            begin
                out_sv_reg    <= 1'b1;
                out_short_reg <= min_gap_next;
                out_long_reg  <= s1_span_reg;
            end
            else
            begin
                out_sv_reg    <= 1'b0;
                out_short_reg <= '0;
                out_long_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign count         = out_count_reg;
    assign spans_valid   = out_sv_reg;
    assign shortest_span = out_short_reg;
    assign longest_span  = out_long_reg;

endmodule
